FILE: rtl/core/utf8lv_pkg.sv
// shared types and constants of the utf-8 label validator
package utf8lv_pkg;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_BAD_UTF8 = 2'd2,
        ERR_CONTROL  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_item;

    typedef struct packed {
        logic label_done;
        logic label_ok;
        t_err error_code;
    } t_result;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned VALUE_W    = 21;
    localparam int unsigned TDATA_IN_W = 8;
    localparam int unsigned TDATA_OUT_W = 8;

    localparam logic [BYTE_W-1:0]  MAX_LABEL_BYTES_RST = 8'd32;
    localparam logic [COUNT_W-1:0] COUNT_SAT           = 9'd511;

    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
    localparam logic [BYTE_W-1:0] DEL_BYTE   = 8'h7F;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] TAG_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] TAG_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] TAG_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] TAG_LEAD4  = 8'hF0;

    localparam logic [VALUE_W-1:0] BOUND_2B   = 21'h00080;
    localparam logic [VALUE_W-1:0] BOUND_3B   = 21'h00800;
    localparam logic [VALUE_W-1:0] BOUND_4B   = 21'h10000;
    localparam logic [VALUE_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [VALUE_W-1:0] SURR_FIRST = 21'h0D800;
    localparam logic [VALUE_W-1:0] SURR_LAST  = 21'h0DFFF;

endpackage

FILE: rtl/core/utf8lv_in_stage.sv
// input register of the label byte stream
module utf8lv_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  utf8lv_pkg::t_item   i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output utf8lv_pkg::t_item   o_item
);

    logic              r_valid;
    logic              n_valid;
    utf8lv_pkg::t_item r_item;
    logic              w_accept;

    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/utf8lv_check.sv
// label state and the per-byte utf-8, control and length checks
module utf8lv_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic                  i_advance,
    input  utf8lv_pkg::t_item     i_item,
    output utf8lv_pkg::t_result   o_result
);

    logic [utf8lv_pkg::BYTE_W-1:0]  r_max;
    logic [1:0]                     r_pending;
    logic [1:0]                     n_pending;
    logic [utf8lv_pkg::VALUE_W-1:0] r_partial;
    logic [utf8lv_pkg::VALUE_W-1:0] n_partial;
    logic [1:0]                     r_class;
    logic [1:0]                     n_class;
    logic [utf8lv_pkg::COUNT_W-1:0] r_byte_count;
    logic [utf8lv_pkg::COUNT_W-1:0] n_byte_count;
    utf8lv_pkg::t_err               r_sticky;
    utf8lv_pkg::t_err               n_sticky;

    logic [utf8lv_pkg::BYTE_W-1:0]  w_byte;
    logic [utf8lv_pkg::COUNT_W-1:0] w_count;
    logic [utf8lv_pkg::VALUE_W-1:0] w_shifted;
    logic [utf8lv_pkg::VALUE_W-1:0] w_bound;
    logic                           w_too_long;
    logic                           w_control;
    logic                           w_bad_utf8;
    logic [1:0]                     w_pending;
    utf8lv_pkg::t_err               w_err;

    assign w_byte    = i_item.data_byte;
    assign w_shifted = {r_partial[utf8lv_pkg::VALUE_W-7:0], w_byte[5:0]};

    always_comb begin
        case (r_class)
            2'd1:    w_bound = utf8lv_pkg::BOUND_2B;
            2'd2:    w_bound = utf8lv_pkg::BOUND_3B;
            default: w_bound = utf8lv_pkg::BOUND_4B;
        endcase
    end

    always_comb begin
        w_count = (r_byte_count == utf8lv_pkg::COUNT_SAT) ? r_byte_count
                                                          : r_byte_count + 9'd1;
        w_too_long = w_count > {1'b0, r_max};
        w_control  = (w_byte < utf8lv_pkg::CTRL_LIMIT) || (w_byte == utf8lv_pkg::DEL_BYTE);

        w_bad_utf8 = 1'b0;
        w_pending  = r_pending;
        n_partial  = r_partial;
        n_class    = r_class;

        if (r_pending != 2'd0) begin
            if ((w_byte & utf8lv_pkg::MASK_CONT) != utf8lv_pkg::TAG_CONT) begin
                w_bad_utf8 = 1'b1;
                w_pending  = 2'd0;
                n_partial  = '0;
                n_class    = 2'd0;
            end else begin
                n_partial = w_shifted;
                w_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    if ((w_shifted < w_bound) || (w_shifted > utf8lv_pkg::CP_MAX) ||
                        ((w_shifted >= utf8lv_pkg::SURR_FIRST) &&
                         (w_shifted <= utf8lv_pkg::SURR_LAST))) begin
                        w_bad_utf8 = 1'b1;
                    end
                end
            end
        end else if (w_byte[7]) begin
            if ((w_byte & utf8lv_pkg::MASK_LEAD2) == utf8lv_pkg::TAG_LEAD2) begin
                w_pending = 2'd1;
                n_partial = {16'd0, w_byte[4:0]};
                n_class   = 2'd1;
            end else if ((w_byte & utf8lv_pkg::MASK_LEAD3) == utf8lv_pkg::TAG_LEAD3) begin
                w_pending = 2'd2;
                n_partial = {17'd0, w_byte[3:0]};
                n_class   = 2'd2;
            end else if ((w_byte & utf8lv_pkg::MASK_LEAD4) == utf8lv_pkg::TAG_LEAD4) begin
                w_pending = 2'd3;
                n_partial = {18'd0, w_byte[2:0]};
                n_class   = 2'd3;
            end else begin
                w_bad_utf8 = 1'b1;
            end
        end

        // character cut short by the end of the label
        if (i_item.last && (w_pending != 2'd0)) begin
            w_bad_utf8 = 1'b1;
        end

        // lowest nonzero code wins
        if ((r_sticky == utf8lv_pkg::ERR_TOO_LONG) || w_too_long) begin
            w_err = utf8lv_pkg::ERR_TOO_LONG;
        end else if ((r_sticky == utf8lv_pkg::ERR_BAD_UTF8) || w_bad_utf8) begin
            w_err = utf8lv_pkg::ERR_BAD_UTF8;
        end else if ((r_sticky == utf8lv_pkg::ERR_CONTROL) || w_control) begin
            w_err = utf8lv_pkg::ERR_CONTROL;
        end else begin
            w_err = utf8lv_pkg::ERR_NONE;
        end

        o_result.label_done = i_item.last;
        o_result.label_ok   = (w_err == utf8lv_pkg::ERR_NONE);
        o_result.error_code = w_err;

        if (i_item.last) begin
            n_pending    = 2'd0;
            n_partial    = '0;
            n_class      = 2'd0;
            n_byte_count = '0;
            n_sticky     = utf8lv_pkg::ERR_NONE;
        end else begin
            n_pending    = w_pending;
            n_byte_count = w_count;
            n_sticky     = w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= utf8lv_pkg::MAX_LABEL_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            r_max <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 2'd0;
            r_partial    <= '0;
            r_class      <= 2'd0;
            r_byte_count <= '0;
            r_sticky     <= utf8lv_pkg::ERR_NONE;
        end else if (i_advance) begin
            r_pending    <= n_pending;
            r_partial    <= n_partial;
            r_class      <= n_class;
            r_byte_count <= n_byte_count;
            r_sticky     <= n_sticky;
        end
    end

    // label end clears the whole label state
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.last |=>
            (r_pending == 2'd0) && (r_byte_count == '0) &&
            (r_sticky == utf8lv_pkg::ERR_NONE))
        else $error("label state not cleared after last byte");

    // an error once seen never drops back within a label
    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_item.last && (r_sticky != utf8lv_pkg::ERR_NONE) |=>
            (r_sticky != utf8lv_pkg::ERR_NONE) && (r_sticky <= $past(r_sticky)))
        else $error("sticky error lost or lowered in priority");

    // an open character always has a form class
    a_pending_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd0) |-> (r_class != 2'd0) && (r_pending <= r_class))
        else $error("pending continuation without matching class");

endmodule

FILE: rtl/core/utf8lv_out_stage.sv
// result register and flow control toward the receiver
module utf8lv_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  utf8lv_pkg::t_result   i_result,
    output logic                  o_advance,
    output logic                  o_valid,
    input  logic                  i_ready,
    output utf8lv_pkg::t_result   o_result
);

    logic                r_valid;
    logic                n_valid;
    utf8lv_pkg::t_result r_result;

    assign o_advance = i_in_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_advance) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/core/utf8_label_validator.sv
// top level of the utf-8 label validator
//
// a label enters on the s_axis channel one byte per request, tlast on its
// final byte. every byte gives one result request on m_axis: tlast copies the
// byte's tlast, tdata[0] is 1 while no error has been seen, tdata[2:1] is the
// error code (0 none, 1 too long, 2 bad utf-8, 3 control byte). on the final
// byte the verdict is complete and the label state clears for the next label.
// the maximum label length is set through i_cfg_wr_en / i_cfg_wr_data.
// a result reaches m_axis after its byte is accepted through the input register,
// then the check logic into the result register. throughput is one byte per cycle
// while m_axis takes results; the checker updates the label state once per byte.
// synchronous active-low reset empties both registers, clears the label state
// and sets the maximum to 32. when m_axis stalls the result is held, one more
// byte waits in the input register, then s_axis_tready drops until the
// receiver takes the held result.
module utf8_label_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] label_ok, [2:1] error_code, [7:3] zero
    output logic        m_axis_tlast
);

    utf8lv_pkg::t_item   w_in_item;
    utf8lv_pkg::t_item   w_stage_item;
    utf8lv_pkg::t_result w_check_result;
    utf8lv_pkg::t_result w_out_result;
    logic                w_stage_valid;
    logic                w_advance;

    assign w_in_item.data_byte = s_axis_tdata;
    assign w_in_item.last      = s_axis_tlast;

    utf8lv_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    utf8lv_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (w_advance),
        .i_item        (w_stage_item),
        .o_result      (w_check_result)
    );

    utf8lv_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (w_stage_valid),
        .i_result   (w_check_result),
        .o_advance  (w_advance),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_out_result)
    );

    assign m_axis_tlast = w_out_result.label_done;
    assign m_axis_tdata = {5'd0, w_out_result.error_code, w_out_result.label_ok};

endmodule

FILE: dv/utf8_label_validator_checker.sv
// checker of the utf-8 label validator: predicts the verdict of every byte and compares
module utf8_label_validator_checker
    import utf8lv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] data_byte
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,   // [0] label_ok, [2:1] error_code, [7:3] zero
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_open_count
);

    localparam logic [1:0] FORM_NONE = 2'd0;
    localparam logic [1:0] FORM_2B   = 2'd1;
    localparam logic [1:0] FORM_3B   = 2'd2;
    localparam logic [1:0] FORM_4B   = 2'd3;

    logic [7:0]         max_bytes;
    logic [1:0]         cont_left;
    logic [VALUE_W-1:0] cp_value;
    logic [1:0]         form_class;
    logic [COUNT_W-1:0] byte_total;
    t_err               label_err;
    t_result            pending_verdicts[$];
    int                 fails = 0;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
        fails++;
    endtask

    // keeps the code of highest priority, which is the lowest nonzero one
    task automatic flag_error(input t_err code);
        if (label_err == ERR_NONE || code < label_err) begin
            label_err = code;
        end
    endtask

    task automatic clear_label();
        cont_left  = 2'd0;
        cp_value   = '0;
        form_class = FORM_NONE;
        byte_total = '0;
        label_err  = ERR_NONE;
    endtask

    task automatic check_code_point();
        logic [VALUE_W-1:0] floor_v;
        case (form_class)
            FORM_2B: begin
                floor_v = BOUND_2B;
            end
            FORM_3B: begin
                floor_v = BOUND_3B;
            end
            default: begin
                floor_v = BOUND_4B;
            end
        endcase
        if (cp_value < floor_v || cp_value > CP_MAX ||
            (cp_value >= SURR_FIRST && cp_value <= SURR_LAST)) begin
            flag_error(ERR_BAD_UTF8);
        end
    endtask

    task automatic predict_verdict(input logic [7:0] b, input logic l, output t_result r);
        if (byte_total < COUNT_SAT) begin
            byte_total++;
        end
        if (byte_total > {1'b0, max_bytes}) begin
            flag_error(ERR_TOO_LONG);
        end
        if (b < CTRL_LIMIT || b == DEL_BYTE) begin
            flag_error(ERR_CONTROL);
        end
        if (cont_left != 2'd0) begin
            if ((b & MASK_CONT) != TAG_CONT) begin
                // broken character is dropped, the byte is not taken as a lead
                flag_error(ERR_BAD_UTF8);
                cont_left  = 2'd0;
                cp_value   = '0;
                form_class = FORM_NONE;
            end else begin
                cp_value = {cp_value[VALUE_W-7:0], b[5:0]};
                cont_left--;
                if (cont_left == 2'd0) begin
                    check_code_point();
                end
            end
        end else if (b[7]) begin
            if ((b & MASK_LEAD2) == TAG_LEAD2) begin
                cont_left  = 2'd1;
                cp_value   = {16'd0, b[4:0]};
                form_class = FORM_2B;
            end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
                cont_left  = 2'd2;
                cp_value   = {17'd0, b[3:0]};
                form_class = FORM_3B;
            end else if ((b & MASK_LEAD4) == TAG_LEAD4) begin
                cont_left  = 2'd3;
                cp_value   = {18'd0, b[2:0]};
                form_class = FORM_4B;
            end else begin
                flag_error(ERR_BAD_UTF8);
            end
        end
        // character cut short by the end of the label
        if (l && cont_left != 2'd0) begin
            flag_error(ERR_BAD_UTF8);
        end
        r.label_done = l;
        r.label_ok   = (label_err == ERR_NONE);
        r.error_code = label_err;
        if (l) begin
            clear_label();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result next_verdict;
        if (!i_rst_n) begin
            max_bytes = MAX_LABEL_BYTES_RST;
            clear_label();
            pending_verdicts.delete();
        end else begin
            if (i_cfg_wr_en) begin
                max_bytes = i_cfg_wr_data;
            end
            // results first, so a byte taken in this cycle is never matched here
            if (i_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 8'h00, i_out_data);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_out_last !== want.label_done) begin
                        report_mismatch("label_done", 8'(want.label_done), 8'(i_out_last));
                    end
                    if (i_out_data[0] !== want.label_ok) begin
                        report_mismatch("label_ok", 8'(want.label_ok), 8'(i_out_data[0]));
                    end
                    if (i_out_data[2:1] !== want.error_code) begin
                        report_mismatch("error_code", 8'(want.error_code),
                                        8'(i_out_data[2:1]));
                    end
                    if (i_out_data[7:3] !== 5'd0) begin
                        report_mismatch("tdata padding", 8'h00, 8'(i_out_data[7:3]));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_verdict(i_in_data, i_in_last, next_verdict);
                pending_verdicts = {pending_verdicts, next_verdict};
            end
        end
        o_fail_count <= fails;
        o_open_count <= pending_verdicts.size();
    end

endmodule

FILE: dv/utf8_label_validator_test.sv
// testbench top of the utf-8 label validator: reset, label stimulus, verdict
module utf8_label_validator_test;
    import utf8lv_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] data_byte
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [0] label_ok, [2:1] error_code, [7:3] zero
    logic       m_axis_tlast;

    int         fail_count;
    int         open_count;
    logic       steady;
    logic [7:0] label_limit;
    logic [7:0] label_bytes[$];
    int         bytes_sent;

    always #2 i_clk = ~i_clk;

    utf8_label_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_label_validator_checker verdict_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_open_count  (open_count)
    );

    // receiver stalls
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 29);
    end

    task automatic send_label();
        for (int i = 0; i < label_bytes.size(); i++) begin
            while (!steady && $urandom_range(99) < 29) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= label_bytes[i];
            s_axis_tlast  <= (i == label_bytes.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready) begin
                @(posedge i_clk);
            end
            bytes_sent++;
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        label_bytes = {label_bytes, b};
    endtask

    task automatic append_code_point(input logic [20:0] cp, input int len);
        case (len)
            2: begin
                append_byte(TAG_LEAD2 | {3'b0, cp[10:6]});
            end
            3: begin
                append_byte(TAG_LEAD3 | {4'b0, cp[15:12]});
                append_byte(TAG_CONT | {2'b0, cp[11:6]});
            end
            default: begin
                append_byte(TAG_LEAD4 | {5'b0, cp[20:18]});
                append_byte(TAG_CONT | {2'b0, cp[17:12]});
                append_byte(TAG_CONT | {2'b0, cp[11:6]});
            end
        endcase
        append_byte(TAG_CONT | {2'b0, cp[5:0]});
    endtask

    // mostly well-formed characters, some control bytes, noise and broken forms
    task automatic add_char();
        int          kind;
        int          len;
        int          spot;
        logic [20:0] cp;
        logic [7:0]  b;
        kind = $urandom_range(99);
        len  = $urandom_range(2, 4);
        if (kind < 45) begin
            append_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 60) begin
            append_code_point(21'($urandom_range(21'h80, 21'h7FF)), 2);
        end else if (kind < 72) begin
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
            if (cp >= SURR_FIRST && cp <= SURR_LAST) begin
                cp = cp + 21'h800;
            end
            append_code_point(cp, 3);
        end else if (kind < 82) begin
            append_code_point(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
        end else if (kind < 86) begin
            append_byte(8'($urandom_range(255)));
        end else if (kind < 89) begin
            append_byte($urandom_range(1) ? DEL_BYTE : 8'($urandom_range(8'h1F)));
        end else if (kind < 92) begin
            // overlong
            case (len)
                2: begin
                    cp = 21'($urandom_range(21'h7F));
                end
                3: begin
                    cp = 21'($urandom_range(21'h7FF));
                end
                default: begin
                    cp = 21'($urandom_range(21'hFFFF));
                end
            endcase
            append_code_point(cp, len);
        end else if (kind < 94) begin
            append_code_point(21'($urandom_range(SURR_FIRST, SURR_LAST)), 3);
        end else if (kind < 96) begin
            append_code_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        end else if (kind < 98) begin
            // sequence cut short
            append_code_point(21'($urandom_range(21'h1FFFFF)), len);
            repeat ($urandom_range(1, len - 1)) begin
                void'(label_bytes.pop_back());
            end
        end else begin
            // continuation replaced by a byte of another kind
            append_code_point(21'($urandom_range(21'h1FFFFF)), len);
            spot = label_bytes.size() - $urandom_range(1, len - 1);
            b = 8'($urandom_range(255));
            if ((b & MASK_CONT) == TAG_CONT) begin
                b[6] = 1'b1;
            end
            label_bytes[spot] = b;
        end
    endtask

    task automatic make_label();
        int target;
        if ($urandom_range(3) == 0) begin
            target = $urandom_range(1, label_limit + 2);
        end else begin
            target = $urandom_range(1, 8);
        end
        label_bytes.delete();
        while (label_bytes.size() < target) begin
            add_char();
        end
    endtask

    task automatic set_label_limit(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        label_limit = v;
    endtask

    initial begin : stimulus
        logic [7:0] next_limit;
        int         goal;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        steady        = 1'b0;
        label_limit   = MAX_LABEL_BYTES_RST;
        bytes_sent    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed labels
        label_bytes = '{8'h41};
        send_label();
        label_bytes = '{8'h20, 8'h7E};
        send_label();
        label_bytes = '{8'h00, 8'h7F};
        send_label();
        label_bytes = '{8'hC3, 8'hA9};
        send_label();
        label_bytes = '{8'hC0, 8'h80};
        send_label();
        label_bytes = '{8'hED, 8'hA0, 8'h80};
        send_label();
        label_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_label();
        label_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_label();
        label_bytes = '{8'h80, 8'hFF};
        send_label();
        label_bytes = '{8'hE2, 8'h41};
        send_label();
        label_bytes = '{8'hE2, 8'h82};
        send_label();

        // random labels under several length limits
        for (int p = 0; p < 6; p++) begin
            case (p)
                1: begin
                    next_limit = 8'd0;
                end
                2: begin
                    next_limit = 8'd255;
                end
                3: begin
                    next_limit = 8'd1;
                end
                4: begin
                    next_limit = 8'($urandom_range(2, 254));
                end
                default: begin
                    next_limit = 8'd6;
                end
            endcase
            if (p > 0) begin
                set_label_limit(next_limit);
            end
            steady <= (p == 3);
            if (p == 2) begin
                // long enough to saturate the byte count
                label_bytes.delete();
                repeat (600) begin
                    append_byte(8'($urandom_range(8'h20, 8'h7E)));
                end
                send_label();
            end
            goal = bytes_sent + 230;
            while (bytes_sent < goal) begin
                make_label();
                send_label();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : run_limit
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
